// ----- rtl/plac_pkg.sv -----
`timescale 1ns / 1ps

package plac_pkg;

  // default packing of one vector component / color channel
  localparam int COMPONENT_BITS_DEF = 16;

  // internal fixed-point widths (components are brought to Q.14 in 16 bits)
  localparam int COMP_W = 16;
  localparam int SUM_W  = 48;
  localparam int NL_W   = 20;
  localparam int R_W    = 23;
  localparam int ROOT_W = SUM_W / 2;
  localparam int REM_W  = ROOT_W + 3;
  localparam int ACC_W  = 24;
  localparam int STEP_W = 5;

  localparam logic [14:0]      ONE_Q14 = 15'd16384;
  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  // iteration counts of the serial units
  localparam logic [STEP_W-1:0] SQRT_STEPS = STEP_W'(ROOT_W);
  localparam logic [STEP_W-1:0] DIV_STEPS  = 5'd15;
  localparam logic [STEP_W-1:0] LOG_LAST   = 5'd15;
  localparam logic [STEP_W-1:0] EXP_LAST   = 5'd15;

  // channel term phases
  localparam logic [STEP_W-1:0] CH_KD   = 5'd0;
  localparam logic [STEP_W-1:0] CH_KS   = 5'd1;
  localparam logic [STEP_W-1:0] CH_FALL = 5'd2;
  localparam logic [STEP_W-1:0] CH_COL  = 5'd3;
  localparam logic [STEP_W-1:0] CH_SH   = 5'd4;

  // configuration register indexes
  localparam logic [2:0] REG_DIFFUSE_RED    = 3'd0;
  localparam logic [2:0] REG_DIFFUSE_GREEN  = 3'd1;
  localparam logic [2:0] REG_DIFFUSE_BLUE   = 3'd2;
  localparam logic [2:0] REG_SPECULAR_RED   = 3'd3;
  localparam logic [2:0] REG_SPECULAR_GREEN = 3'd4;
  localparam logic [2:0] REG_SPECULAR_BLUE  = 3'd5;
  localparam logic [2:0] REG_GLOSS          = 3'd6;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_NL, S_REFL, S_LEN2, S_SQRT, S_DIV, S_VR,
    S_SPEC, S_NORM, S_LOG, S_GMUL, S_EXP, S_SHIFT, S_CH, S_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_NL, OP_REFL, OP_LEN2, OP_SQRT, OP_DIV, OP_VR,
    OP_SPEC, OP_NORM, OP_LOG, OP_GMUL, OP_EXP, OP_SHIFT, OP_CH, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [1:0]        lane;
    logic [STEP_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic light_valid;
    logic last_light;
    logic l_nonzero;
    logic spec_direct;
    logic norm_done;
    logic out_free;
  } sts_t;

  // floor square root, evaluated at elaboration only
  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    v   = x;
    res = '0;
    b   = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // 2^(-2^-j) in Q.30, each the root of the one before
  function automatic logic [29:0] exp2_root(input int j);
    logic [63:0] c;
    c = 64'd1 << 29;
    for (int i = 1; i <= j; i++) begin
      c = isqrt64(c << 30);
    end
    return c[29:0];
  endfunction

endpackage

// ----- rtl/phong_light_accumulator.sv -----
`timescale 1ns / 1ps
// channel   handshake                 beat contents
// in        in_valid / in_stall       one light of a surface point
// out       out_valid / out_stall     shaded rgb of the point, Q4.12
// cfg       cfg_valid / cfg_ready     register index and 16-bit value
//
// one light at a time: a skipped light (invalid or zero direction) goes back to
// idle after the check, a lit light skips the log/exp power path when the specular
// term is trivial; a last light then loads the output register
// the bit-serial square root and divider, the 16-step log and exp loops and the
// single shared multiplier set the time that a lit light takes
// rst_n is synchronous: clears the accumulators, configuration registers and the output beat
// a stalled result stays in the output register; the next light is taken meanwhile,
// only a new result waits for the old one to leave

module phong_light_accumulator #(
  parameter int COMPONENT_BITS = plac_pkg::COMPONENT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // light input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [47:0] in_surface_normal,
  input  logic [47:0] in_light_dir,
  input  logic [47:0] in_ray_dir,
  input  logic [47:0] in_light_rgb,
  input  logic [47:0] in_shadow_rgb,
  input  logic [15:0] in_falloff,
  input  logic        in_light_valid,
  input  logic        in_last_light,
  // shaded result
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_red,
  output logic [15:0] out_green,
  output logic [15:0] out_blue,
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  plac_pkg::cmd_t cmd;
  plac_pkg::sts_t sts;

  // registers are always writable
  assign cfg_ready = 1'b1;

  // sequencer: walks dot products, root, divides, log/exp and channel terms
  plac_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: shared multiplier, serial root/divide, accumulators, output beat
  plac_dp #(
    .COMPONENT_BITS (COMPONENT_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_surface_normal (in_surface_normal),
    .in_light_dir      (in_light_dir),
    .in_ray_dir        (in_ray_dir),
    .in_light_rgb      (in_light_rgb),
    .in_shadow_rgb     (in_shadow_rgb),
    .in_falloff        (in_falloff),
    .in_light_valid    (in_light_valid),
    .in_last_light     (in_last_light),
    .cfg_valid         (cfg_valid & cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue)
  );

endmodule

// ----- rtl/plac_ctrl.sv -----
`timescale 1ns / 1ps

module plac_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  plac_pkg::sts_t  sts,
  output plac_pkg::cmd_t  cmd
);

  plac_pkg::state_t state_r, state_nxt;
  logic [1:0]                  lane_r, lane_nxt;
  logic [plac_pkg::STEP_W-1:0] step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= plac_pkg::S_IDLE;
      lane_r  <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      lane_r  <= lane_nxt;
      step_r  <= step_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    lane_nxt  = lane_r;
    step_nxt  = step_r;
    case (state_r)
      plac_pkg::S_IDLE: begin
        if (in_valid) state_nxt = plac_pkg::S_CHECK;
      end
      plac_pkg::S_CHECK: begin
        lane_nxt = '0;
        step_nxt = '0;
        if (sts.light_valid && sts.l_nonzero) state_nxt = plac_pkg::S_NL;
        else if (sts.last_light)              state_nxt = plac_pkg::S_EMIT;
        else                                  state_nxt = plac_pkg::S_IDLE;
      end
      plac_pkg::S_NL, plac_pkg::S_REFL, plac_pkg::S_LEN2, plac_pkg::S_VR: begin
        if (lane_r == 2'd2) begin
          lane_nxt = '0;
          step_nxt = '0;
          case (state_r)
            plac_pkg::S_NL:   state_nxt = plac_pkg::S_REFL;
            plac_pkg::S_REFL: state_nxt = plac_pkg::S_LEN2;
            plac_pkg::S_LEN2: state_nxt = plac_pkg::S_SQRT;
            default:          state_nxt = plac_pkg::S_SPEC;
          endcase
        end else begin
          lane_nxt = lane_r + 2'd1;
        end
      end
      plac_pkg::S_SQRT: begin
        if (step_r == plac_pkg::SQRT_STEPS) begin
          step_nxt  = '0;
          lane_nxt  = '0;
          state_nxt = plac_pkg::S_DIV;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      plac_pkg::S_DIV: begin
        if (step_r == plac_pkg::DIV_STEPS) begin
          step_nxt = '0;
          if (lane_r == 2'd2) begin
            lane_nxt  = '0;
            state_nxt = plac_pkg::S_VR;
          end else begin
            lane_nxt = lane_r + 2'd1;
          end
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      plac_pkg::S_SPEC: begin
        lane_nxt = '0;
        step_nxt = '0;
        state_nxt = sts.spec_direct ? plac_pkg::S_CH : plac_pkg::S_NORM;
      end
      plac_pkg::S_NORM: begin
        step_nxt = '0;
        if (sts.norm_done) state_nxt = plac_pkg::S_LOG;
      end
      plac_pkg::S_LOG: begin
        if (step_r == plac_pkg::LOG_LAST) begin
          step_nxt  = '0;
          state_nxt = plac_pkg::S_GMUL;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      plac_pkg::S_GMUL: begin
        step_nxt  = '0;
        state_nxt = plac_pkg::S_EXP;
      end
      plac_pkg::S_EXP: begin
        if (step_r == plac_pkg::EXP_LAST) begin
          step_nxt  = '0;
          state_nxt = plac_pkg::S_SHIFT;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      plac_pkg::S_SHIFT: begin
        lane_nxt  = '0;
        step_nxt  = '0;
        state_nxt = plac_pkg::S_CH;
      end
      plac_pkg::S_CH: begin
        if (step_r == plac_pkg::CH_SH) begin
          step_nxt = '0;
          if (lane_r == 2'd2) begin
            lane_nxt  = '0;
            state_nxt = sts.last_light ? plac_pkg::S_EMIT : plac_pkg::S_IDLE;
          end else begin
            lane_nxt = lane_r + 2'd1;
          end
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      plac_pkg::S_EMIT: begin
        if (sts.out_free) state_nxt = plac_pkg::S_IDLE;
      end
      default: state_nxt = plac_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd.lane = lane_r;
    cmd.step = step_r;
    in_stall = (state_r != plac_pkg::S_IDLE);
    case (state_r)
      plac_pkg::S_IDLE:  cmd.op = in_valid ? plac_pkg::OP_LOAD : plac_pkg::OP_NONE;
      plac_pkg::S_CHECK: cmd.op = plac_pkg::OP_NONE;
      plac_pkg::S_NL:    cmd.op = plac_pkg::OP_NL;
      plac_pkg::S_REFL:  cmd.op = plac_pkg::OP_REFL;
      plac_pkg::S_LEN2:  cmd.op = plac_pkg::OP_LEN2;
      plac_pkg::S_SQRT:  cmd.op = plac_pkg::OP_SQRT;
      plac_pkg::S_DIV:   cmd.op = plac_pkg::OP_DIV;
      plac_pkg::S_VR:    cmd.op = plac_pkg::OP_VR;
      plac_pkg::S_SPEC:  cmd.op = plac_pkg::OP_SPEC;
      plac_pkg::S_NORM:  cmd.op = plac_pkg::OP_NORM;
      plac_pkg::S_LOG:   cmd.op = plac_pkg::OP_LOG;
      plac_pkg::S_GMUL:  cmd.op = plac_pkg::OP_GMUL;
      plac_pkg::S_EXP:   cmd.op = plac_pkg::OP_EXP;
      plac_pkg::S_SHIFT: cmd.op = plac_pkg::OP_SHIFT;
      plac_pkg::S_CH:    cmd.op = plac_pkg::OP_CH;
      plac_pkg::S_EMIT:  cmd.op = sts.out_free ? plac_pkg::OP_EMIT : plac_pkg::OP_NONE;
      default:           cmd.op = plac_pkg::OP_NONE;
    endcase
  end

endmodule

// ----- rtl/plac_dp.sv -----
`timescale 1ns / 1ps

module plac_dp #(
  parameter int COMPONENT_BITS = plac_pkg::COMPONENT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  plac_pkg::cmd_t      cmd,
  output plac_pkg::sts_t      sts,
  input  logic [47:0]         in_surface_normal,
  input  logic [47:0]         in_light_dir,
  input  logic [47:0]         in_ray_dir,
  input  logic [47:0]         in_light_rgb,
  input  logic [47:0]         in_shadow_rgb,
  input  logic [15:0]         in_falloff,
  input  logic                in_light_valid,
  input  logic                in_last_light,
  input  logic                cfg_valid,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [15:0]         out_red,
  output logic [15:0]         out_green,
  output logic [15:0]         out_blue
);

  localparam int CB  = COMPONENT_BITS;
  localparam int PW  = (3 * CB > 48) ? 3 * CB : 48;
  localparam int SHR = (CB >= 16) ? CB - 16 : 0;
  localparam int SHL = (CB < 16) ? 16 - CB : 0;
  localparam int SW  = plac_pkg::SUM_W;
  localparam int RW  = plac_pkg::R_W;
  localparam int AW  = plac_pkg::ACC_W;

  function automatic logic signed [15:0] sgn_comp(input logic [47:0] word, input int idx);
    logic [PW-1:0]          ext;
    logic [CB-1:0]          raw;
    logic signed [CB+16:0]  wide;
    ext  = PW'(word);
    raw  = ext[idx*CB +: CB];
    wide = signed'({{17{raw[CB-1]}}, raw});
    if (CB >= 16) return 16'(wide >>> SHR);
    else          return 16'(wide <<< SHL);
  endfunction

  function automatic logic [15:0] uns_comp(input logic [47:0] word, input int idx);
    logic [PW-1:0]   ext;
    logic [CB-1:0]   raw;
    logic [CB+16:0]  wide;
    ext  = PW'(word);
    raw  = ext[idx*CB +: CB];
    wide = {17'b0, raw};
    if (CB >= 16) return 16'(wide >> SHR);
    else          return 16'(wide << SHL);
  endfunction

  // configuration, accumulators and output registers
  logic [15:0]   kd_r [3];
  logic [15:0]   ks_r [3];
  logic [15:0]   gloss_r;
  logic [AW-1:0] acc_r [3];
  logic          out_valid_r;
  logic [15:0]   out_r [3];

  // latched light
  logic signed [15:0] n_r [3];
  logic signed [15:0] l_r [3];
  logic signed [15:0] d_r [3];
  logic [15:0]        col_r [3];
  logic [15:0]        sh_r [3];
  logic [15:0]        fall_r;
  logic               vld_r;
  logic               last_r;

  // work registers
  logic signed [SW-1:0]       sum_r;
  logic signed [plac_pkg::NL_W-1:0] nl_r;
  logic signed [RW-1:0]       r_r [3];
  logic signed [15:0]         rn_r [3];
  logic [SW-1:0]              rad_r;
  logic [plac_pkg::REM_W-1:0] rem_r;
  logic [plac_pkg::ROOT_W-1:0] root_r;
  logic [plac_pkg::ROOT_W-1:0] len_r;
  logic [14:0]                m_r;
  logic [3:0]                 k_r;
  logic [31:0]                mant_r;
  logic [15:0]                frac_r;
  logic [10:0]                ip_r;
  logic [15:0]                fp_r;
  logic [30:0]                p_r;
  logic [14:0]                spec_r;
  logic [33:0]                t_r;

  logic [29:0] ctab [16];
  for (genvar j = 0; j < 16; j++) begin : g_ctab
    localparam logic [29:0] CJ = plac_pkg::exp2_root(j + 1);
    assign ctab[j] = CJ;
  end

  // combinational helpers
  logic signed [32:0]          ma, mb;
  logic signed [65:0]          prod;
  logic signed [plac_pkg::NL_W-1:0] nl_w;
  logic signed [SW-1:0]        nsum;
  logic signed [33:0]          vrf;
  logic [14:0]                 vr_w;
  logic [15:0]                 nlc;
  logic [RW-1:0]               rmag;
  logic [plac_pkg::REM_W-1:0]  sq_rem2, sq_trial, dv_rem2;
  logic                        sq_ge, dv_ge;
  logic [plac_pkg::ROOT_W-1:0] sq_root, dv_q;
  logic [31:0]                 sq_mant;
  logic [19:0]                 neg_log;
  logic [26:0]                 t_exp;
  logic [34:0]                 ch_sum;
  logic [AW+1:0]               acc_sum;
  logic [AW:0]                 emit_sum [3];
  logic [AW-2:0]               emit_q [3];
  logic [1:0]                  ln;

  assign ln   = cmd.lane;
  assign prod = ma * mb;
  assign nl_w = plac_pkg::NL_W'(sum_r >>> 14);
  assign nsum = -sum_r;
  assign vrf  = 34'(nsum >>> 14);

  always_comb begin
    if (vrf < 34'sd0)           vr_w = '0;
    else if (vrf > 34'sd16384)  vr_w = plac_pkg::ONE_Q14;
    else                        vr_w = vrf[14:0];
    if (nl_r < 0)                         nlc = '0;
    else if (nl_r > 20'sd65535)           nlc = 16'hFFFF;
    else                                  nlc = nl_r[15:0];
  end

  // isqrt digit step, divide step, product slices and channel/emit sums
  always_comb begin
    rmag     = r_r[ln][RW-1] ? RW'(-r_r[ln]) : RW'(r_r[ln]);
    sq_rem2  = {rem_r[plac_pkg::REM_W-3:0], rad_r[SW-1:SW-2]};
    sq_trial = plac_pkg::REM_W'({root_r, 2'b01});
    sq_ge    = (sq_rem2 >= sq_trial);
    sq_root  = {root_r[plac_pkg::ROOT_W-2:0], sq_ge};
    dv_rem2  = {rem_r[plac_pkg::REM_W-2:0], rad_r[SW-1]};
    dv_ge    = (dv_rem2 >= plac_pkg::REM_W'(len_r));
    dv_q     = {root_r[plac_pkg::ROOT_W-2:0], dv_ge};
    sq_mant  = prod[61:30];
    neg_log  = {k_r, 16'b0} - {4'b0, frac_r};
    t_exp    = prod[35:9];
    ch_sum   = 35'(t_r) + 35'(prod[32:0]);
    acc_sum  = (AW+2)'(acc_r[ln]) + (AW+2)'(prod[38:14]);
    for (int i = 0; i < 3; i++) begin
      emit_sum[i] = (AW+1)'(kd_r[i]) + (AW+1)'(acc_r[i]);
      emit_q[i]   = emit_sum[i][AW:2];
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      plac_pkg::OP_NL:   begin ma = 33'(n_r[ln]);  mb = 33'(l_r[ln]); end
      plac_pkg::OP_REFL: begin ma = 33'(nl_w);     mb = 33'(n_r[ln]); end
      plac_pkg::OP_LEN2: begin ma = 33'(r_r[ln]);  mb = 33'(r_r[ln]); end
      plac_pkg::OP_VR:   begin ma = 33'(rn_r[ln]); mb = 33'(d_r[ln]); end
      plac_pkg::OP_LOG:  begin ma = signed'({1'b0, mant_r}); mb = signed'({1'b0, mant_r}); end
      plac_pkg::OP_GMUL: begin
        ma = signed'({13'b0, neg_log});
        mb = signed'({17'b0, gloss_r});
      end
      plac_pkg::OP_EXP:  begin
        ma = signed'({2'b0, p_r});
        mb = signed'({3'b0, ctab[cmd.step[3:0]]});
      end
      plac_pkg::OP_CH: begin
        case (cmd.step)
          plac_pkg::CH_KD:   begin ma = signed'({17'b0, nlc});    mb = signed'({17'b0, kd_r[ln]}); end
          plac_pkg::CH_KS:   begin ma = signed'({18'b0, spec_r}); mb = signed'({17'b0, ks_r[ln]}); end
          plac_pkg::CH_FALL: begin ma = signed'({1'b0, t_r[31:0]}); mb = signed'({17'b0, fall_r}); end
          plac_pkg::CH_COL:  begin ma = signed'({1'b0, t_r[31:0]}); mb = signed'({17'b0, col_r[ln]}); end
          plac_pkg::CH_SH:   begin ma = signed'({1'b0, t_r[31:0]}); mb = signed'({17'b0, sh_r[ln]}); end
          default:           begin ma = '0; mb = '0; end
        endcase
      end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // control, configuration, accumulators and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        kd_r[i]  <= '0;
        ks_r[i]  <= '0;
        acc_r[i] <= '0;
      end
      gloss_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          plac_pkg::REG_DIFFUSE_RED:    kd_r[0] <= cfg_data;
          plac_pkg::REG_DIFFUSE_GREEN:  kd_r[1] <= cfg_data;
          plac_pkg::REG_DIFFUSE_BLUE:   kd_r[2] <= cfg_data;
          plac_pkg::REG_SPECULAR_RED:   ks_r[0] <= cfg_data;
          plac_pkg::REG_SPECULAR_GREEN: ks_r[1] <= cfg_data;
          plac_pkg::REG_SPECULAR_BLUE:  ks_r[2] <= cfg_data;
          plac_pkg::REG_GLOSS:          gloss_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (cmd.op == plac_pkg::OP_CH && cmd.step == plac_pkg::CH_SH) begin
        acc_r[ln] <= (acc_sum > (AW+2)'(plac_pkg::ACC_MAX)) ? plac_pkg::ACC_MAX
                                                            : acc_sum[AW-1:0];
      end
      if (cmd.op == plac_pkg::OP_EMIT) begin
        out_valid_r <= 1'b1;
        for (int i = 0; i < 3; i++) acc_r[i] <= '0;
      end
    end
  end

  // payload, work and output data registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      plac_pkg::OP_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          n_r[i]   <= sgn_comp(in_surface_normal, i);
          l_r[i]   <= sgn_comp(in_light_dir, i);
          d_r[i]   <= sgn_comp(in_ray_dir, i);
          col_r[i] <= uns_comp(in_light_rgb, i);
          sh_r[i]  <= uns_comp(in_shadow_rgb, i);
        end
        fall_r <= in_falloff;
        vld_r  <= in_light_valid;
        last_r <= in_last_light;
      end
      plac_pkg::OP_NL, plac_pkg::OP_LEN2, plac_pkg::OP_VR: begin
        sum_r <= ((ln == 2'd0) ? SW'(0) : sum_r) + SW'(prod);
      end
      plac_pkg::OP_REFL: begin
        nl_r      <= nl_w;
        r_r[ln]   <= RW'(prod >>> 13) - RW'(l_r[ln]);
      end
      plac_pkg::OP_SQRT: begin
        if (cmd.step == '0) begin
          rad_r  <= sum_r;
          rem_r  <= '0;
          root_r <= '0;
        end else begin
          rem_r  <= sq_ge ? sq_rem2 - sq_trial : sq_rem2;
          root_r <= sq_root;
          rad_r  <= rad_r << 2;
          if (cmd.step == plac_pkg::SQRT_STEPS) len_r <= sq_root;
        end
      end
      plac_pkg::OP_DIV: begin
        if (cmd.step == '0) begin
          rem_r  <= plac_pkg::REM_W'(rmag >> 1);
          rad_r  <= {rmag[0], {(SW-1){1'b0}}};
          root_r <= '0;
        end else begin
          rem_r  <= dv_ge ? dv_rem2 - plac_pkg::REM_W'(len_r) : dv_rem2;
          root_r <= dv_q;
          rad_r  <= rad_r << 1;
          if (cmd.step == plac_pkg::DIV_STEPS) begin
            if (len_r == '0)        rn_r[ln] <= '0;
            else if (r_r[ln][RW-1]) rn_r[ln] <= -signed'(dv_q[15:0]);
            else                    rn_r[ln] <= signed'(dv_q[15:0]);
          end
        end
      end
      plac_pkg::OP_SPEC: begin
        m_r    <= vr_w;
        k_r    <= '0;
        spec_r <= (gloss_r == '0 || vr_w == plac_pkg::ONE_Q14) ? plac_pkg::ONE_Q14 : '0;
      end
      plac_pkg::OP_NORM: begin
        if (!m_r[14]) begin
          m_r <= m_r << 1;
          k_r <= k_r + 4'd1;
        end else begin
          mant_r <= {1'b0, m_r, 16'b0};
        end
      end
      plac_pkg::OP_LOG: begin
        frac_r <= {frac_r[14:0], sq_mant[31]};
        mant_r <= sq_mant[31] ? (sq_mant >> 1) : sq_mant;
      end
      plac_pkg::OP_GMUL: begin
        ip_r <= t_exp[26:16];
        fp_r <= t_exp[15:0];
        p_r  <= 31'd1 << 30;
      end
      plac_pkg::OP_EXP: begin
        if (fp_r[15]) p_r <= prod[60:30];
        fp_r <= fp_r << 1;
      end
      plac_pkg::OP_SHIFT: begin
        spec_r <= (ip_r >= 11'd15) ? '0 : 15'(p_r >> (5'd16 + 5'(ip_r[3:0])));
      end
      plac_pkg::OP_CH: begin
        case (cmd.step)
          plac_pkg::CH_KD:   t_r <= 34'(prod[31:0]);
          plac_pkg::CH_KS:   t_r <= 34'(ch_sum >> 14);
          plac_pkg::CH_FALL: t_r <= 34'(prod[34:14]);
          plac_pkg::CH_COL:  t_r <= 34'(prod[36:14]);
          default: ;
        endcase
      end
      plac_pkg::OP_EMIT: begin
        for (int i = 0; i < 3; i++) begin
          out_r[i] <= (emit_q[i] > (AW-1)'(16'hFFFF)) ? 16'hFFFF : emit_q[i][15:0];
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    sts.light_valid = vld_r;
    sts.last_light  = last_r;
    sts.l_nonzero   = (l_r[0] != '0) || (l_r[1] != '0) || (l_r[2] != '0);
    sts.spec_direct = (gloss_r == '0) || (vr_w == plac_pkg::ONE_Q14) || (vr_w == '0);
    sts.norm_done   = m_r[14];
    sts.out_free    = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_r[0];
  assign out_green = out_r[1];
  assign out_blue  = out_r[2];

endmodule

// ----- rtl/plac_chk.sv -----
`timescale 1ns / 1ps

module plac_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_light_valid,
  input logic        in_last_light,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_red,
  input logic [15:0] out_green,
  input logic [15:0] out_blue
);

  // a held result beat keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_red) && $stable(out_green)
                               && $stable(out_blue))
    else $error("result beat changed while stalled");

  // reset leaves no result pending
  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a taken light keeps the block busy on the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second light taken back to back");

  // an empty, non-final light is dropped: the block checks it and goes back to idle
  a_skip: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_light_valid && !in_last_light |-> ##2 !in_stall)
    else $error("skipped light did not return to idle");

  // a new result appears only as the block goes idle
  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("result raised while busy");

endmodule

bind phong_light_accumulator plac_chk u_plac_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_light_valid (in_light_valid),
  .in_last_light  (in_last_light),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_red        (out_red),
  .out_green      (out_green),
  .out_blue       (out_blue)
);
